[rtl/core/swst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swst_pkg
// Shared types, constants and helpers of the sequence window slot tracker.
// ----------------------------------------------------------------------------
package swst_pkg;

    // ring geometry: slot index is the low bits of the sequence number
    localparam int SLOT_W    = 4;
    localparam int SLOTS     = 1 << SLOT_W;
    localparam int SIZE_BITS = 24;
    localparam int SEQ_W     = 32;
    localparam int CNT_W     = SLOT_W + 1;

    // command codes
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // input transaction
    typedef struct packed {
        logic              cmd;
        logic [31:0]       seq_num;
        logic [23:0]       chunk_size;
    } t_in;

    // output transaction
    typedef struct packed {
        logic              ok;
        logic [3:0]        slot;
        logic [23:0]       found_size;
        logic [31:0]       newest;
        logic [31:0]       oldest;
        logic [15:0]       presence_map;
    } t_out;

    // classified job handed from front to back
    typedef struct packed {
        logic                 cmd;
        logic [SEQ_W-1:0]     seq;
        logic [SLOT_W-1:0]    slot;
        logic [SIZE_BITS-1:0] size;
    } t_job;

    // oldest sequence of the window for a given newest sequence
    function automatic logic [SEQ_W-1:0] oldest_of(input logic [SEQ_W-1:0] n);
        logic [SEQ_W-1:0] res;
        if (n < SEQ_W'(SLOTS)) begin
            res = (n != '0) ? SEQ_W'(1) : '0;
        end else begin
            res = n - SEQ_W'(SLOTS) + SEQ_W'(1);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[rtl/core/swst_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swst_front
// Accepts input transactions, classifies them into jobs (command, slot,
// masked size) and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module swst_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire swst_pkg::t_in i_data,
    output logic               o_job_valid,
    output swst_pkg::t_job     o_job,
    input  wire logic          i_job_pop
);

    localparam int QDEPTH = 2;

    swst_pkg::t_job r_q [QDEPTH];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           w_push;
    logic           w_pop;
    swst_pkg::t_job w_job;

    // classify the incoming transaction
    always_comb begin
        w_job.cmd  = i_data.cmd;
        w_job.seq  = i_data.seq_num;
        w_job.slot = i_data.seq_num[swst_pkg::SLOT_W-1:0];
        w_job.size = i_data.chunk_size[swst_pkg::SIZE_BITS-1:0];
    end

    assign o_ready     = (r_count != 2'(QDEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_job_valid = (r_count != 2'd0);
    assign w_pop       = i_job_pop && o_job_valid;
    assign o_job       = r_q[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_job;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/core/swst_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swst_back
// Executes jobs against the slot ring: add or lookup through one memory
// port, then a slot-by-slot scan for the presence map, then the result is
// placed in the output register.
// ----------------------------------------------------------------------------
module swst_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_job_valid,
    input  wire swst_pkg::t_job i_job,
    output logic                o_job_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output swst_pkg::t_out      o_data
);

    localparam int SLOT_W = swst_pkg::SLOT_W;
    localparam int SEQ_W  = swst_pkg::SEQ_W;
    localparam int SIZE_W = swst_pkg::SIZE_BITS;
    localparam int CNT_W  = swst_pkg::CNT_W;
    localparam int SLOTS  = swst_pkg::SLOTS;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ACCESS = 6'b000010,
        S_CHECK  = 6'b000100,
        S_SCAN   = 6'b001000,
        S_DONE   = 6'b010000,
        S_WAIT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // slot ring storage and per-slot valid bits
    logic [SEQ_W-1:0]  r_tag_mem [SLOTS];
    logic [SIZE_W-1:0] r_len_mem [SLOTS];
    logic [SLOTS-1:0]  r_slot_vld;

    logic [SEQ_W-1:0]  r_rd_tag;
    logic [SIZE_W-1:0] r_rd_len;
    logic              r_rd_vld;

    // job and window state
    swst_pkg::t_job    r_job;
    logic [SEQ_W-1:0]  r_newest, n_newest;
    logic              r_ok, n_ok;
    logic [SIZE_W-1:0] r_found, n_found;

    // scan state
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [SEQ_W-1:0]  r_exp, n_exp;
    logic              r_pend, n_pend;
    logic [SLOT_W-1:0] r_pidx, n_pidx;
    logic [SEQ_W-1:0]  r_pexp, n_pexp;
    logic [SLOTS-1:0]  r_map, n_map;

    // output register
    logic              r_out_valid;
    swst_pkg::t_out    r_out;

    // memory port control
    logic              w_we;
    logic [SLOT_W-1:0] w_addr;
    logic [CNT_W-1:0]  w_count;
    logic              w_inside;
    logic              w_hit;
    logic              w_out_free;

    // number of window positions to scan: min(newest, SLOTS)
    assign w_count = (r_newest < SEQ_W'(SLOTS)) ? r_newest[CNT_W-1:0] : CNT_W'(SLOTS);

    // lookup window test and tag match on the slot read
    assign w_inside = !((r_newest >= SEQ_W'(SLOTS)) &&
                        (r_job.seq < swst_pkg::oldest_of(r_newest)));
    assign w_hit    = w_inside && r_rd_vld && (r_rd_tag == r_job.seq) &&
                      (r_rd_len != '0);

    assign w_out_free = !r_out_valid || i_ready;
    assign o_job_pop  = (r_state == S_IDLE) && i_job_valid;

    // sequencer next state and datapath
    always_comb begin
        n_state  = r_state;
        n_newest = r_newest;
        n_ok     = r_ok;
        n_found  = r_found;
        n_idx    = r_idx;
        n_exp    = r_exp;
        n_pend   = r_pend;
        n_pidx   = r_pidx;
        n_pexp   = r_pexp;
        n_map    = r_map;
        w_we     = 1'b0;
        w_addr   = r_job.slot;

        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = S_ACCESS;
                end
            end
            S_ACCESS: begin
                n_idx   = '0;
                n_pend  = 1'b0;
                n_map   = '0;
                n_found = '0;
                if (r_job.cmd == swst_pkg::CMD_ADD) begin
                    n_ok = 1'b1;
                    if ((r_job.seq > r_newest) || (r_newest == '0)) begin
                        n_newest = r_job.seq;
                        w_we     = 1'b1;
                    end else if ((r_newest - r_job.seq) >= SEQ_W'(SLOTS)) begin
                        n_ok = 1'b0;
                    end else begin
                        w_we = 1'b1;
                    end
                    n_exp   = n_newest;
                    n_state = S_SCAN;
                end else begin
                    n_exp   = r_newest;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_ok    = w_hit;
                n_found = w_hit ? r_rd_len : '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // issue one slot read per cycle, compare it the next cycle
                w_addr = r_exp[SLOT_W-1:0];
                if (r_idx < w_count) begin
                    n_idx  = r_idx + CNT_W'(1);
                    n_exp  = r_exp - SEQ_W'(1);
                    n_pend = 1'b1;
                    n_pidx = r_idx[SLOT_W-1:0];
                    n_pexp = r_exp;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    n_map[r_pidx] = r_rd_vld && (r_rd_tag == r_pexp) && (r_rd_len != '0);
                end
                if (!(r_idx < w_count) && !r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // slot ring write and registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_tag_mem[r_job.slot] <= r_job.seq;
            r_len_mem[r_job.slot] <= r_job.size;
        end
        r_rd_tag <= r_tag_mem[w_addr];
        r_rd_len <= r_len_mem[w_addr];
    end

    // slot valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (w_we) begin
                r_slot_vld[r_job.slot] <= 1'b1;
            end
            r_rd_vld <= r_slot_vld[w_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_newest <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_newest <= n_newest;
            r_pend   <= n_pend;
        end
    end

    // job and scan payload registers
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        r_ok    <= n_ok;
        r_found <= n_found;
        r_idx   <= n_idx;
        r_exp   <= n_exp;
        r_pidx  <= n_pidx;
        r_pexp  <= n_pexp;
        r_map   <= n_map;
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE || r_state == S_WAIT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE || r_state == S_WAIT) && w_out_free) begin
            r_out.ok           <= r_ok;
            r_out.slot         <= 4'(r_job.slot);
            r_out.found_size   <= 24'(r_found);
            r_out.newest       <= r_newest;
            r_out.oldest       <= swst_pkg::oldest_of(r_newest);
            r_out.presence_map <= 16'(r_map);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

[rtl/core/seq_window_slot_tracker_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seq_window_slot_tracker_unit
// Receive-side sliding window over a ring of sixteen slots keyed by the low
// bits of the sequence number, with a presence map on every result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_ready / i_data carries one command per
//   transaction: add a chunk (sequence and size) or look up a sequence.
//   Output channel o_valid / i_ready / o_data returns exactly one result per
//   input transaction, in order.
//   The presence map is built by reading the slot ring one entry per cycle
//   through its single port, min(newest, 16) entries. A lookup passes one
//   state more than an add (a tag check on the slot read) before the
//   scan, and the result then goes to the output register.
//   The sequencer runs one item at a time and takes no new job until
//   its result has been placed in the output register.
//   A two-entry job queue sits between the input side and the execution
//   sequencer, and the result sits in an output register, so inputs keep
//   being taken while a result waits for the receiver.
//   When the receiver stalls, the finished result is held unchanged; the
//   sequencer waits with the next result and the queue then fills and
//   drops o_ready.
//   Reset clears the newest sequence, the slot valid bits and all queues;
//   the block accepts input in the first cycle after reset.
// ----------------------------------------------------------------------------
module seq_window_slot_tracker_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire swst_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output swst_pkg::t_out      o_data
);

    logic           w_job_valid;
    swst_pkg::t_job w_job;
    logic           w_job_pop;

    // accept and classify
    swst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    // execute against the slot ring
    swst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule
`default_nettype wire
